FILE: hw/rtl/i2cmts_pkg.sv
// Shared types, codes and constants of the I2C master transfer sequencer.
`timescale 1ns / 1ps

package i2cmts_pkg;

   // Receive buffer geometry.
   localparam int BUF_DEPTH = 32;
   localparam int BUF_AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   // Command queue between the front and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam int POS_W = 6;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;
   localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
   localparam logic [7:0] ADDR_READ_BIT = 8'h01;

   // Item function codes.
   localparam logic [2:0] FUNC_START_WRITE = 3'd0;
   localparam logic [2:0] FUNC_START_READ = 3'd1;
   localparam logic [2:0] FUNC_POLL = 3'd2;
   localparam logic [2:0] FUNC_STATUS = 3'd3;
   localparam logic [2:0] FUNC_LOAD = 3'd4;
   localparam logic [2:0] FUNC_READ = 3'd5;

   // Master status codes, low three bits cleared.
   localparam logic [7:0] ST_START = 8'h08;
   localparam logic [7:0] ST_RESTART = 8'h10;
   localparam logic [7:0] ST_MT_ADDR_ACK = 8'h18;
   localparam logic [7:0] ST_MT_ADDR_NACK = 8'h20;
   localparam logic [7:0] ST_MT_DATA_ACK = 8'h28;
   localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_MR_ADDR_ACK = 8'h40;
   localparam logic [7:0] ST_MR_ADDR_NACK = 8'h48;
   localparam logic [7:0] ST_MR_DATA_ACK = 8'h50;
   localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

   typedef enum logic [1:0] {
      PH_FREE    = 2'd0,
      PH_BUSY    = 2'd1,
      PH_SUCCESS = 2'd2,
      PH_FAILURE = 2'd3
   } phase_type;

   // Classified operation carried from the front to the back end.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_POLL,
      OP_ADDR_SENT,
      OP_TX_ACK,
      OP_ADDR_NACK,
      OP_TX_DATA_NACK,
      OP_RX_ADDR_ACK,
      OP_RX_DATA_ACK,
      OP_RX_LAST,
      OP_LOAD,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              rd_dir;
      logic [7:0]        addr;
      logic [POS_W-1:0]  len;
      logic [7:0]        rx_byte;
      logic [4:0]        bidx;
      logic [7:0]        bbyte;
   } cmd_type;

   // Queue handshake signals seen from one side.
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

   function automatic logic pos_in_buf(input logic [POS_W-1:0] p);
      return 32'(p) < 32'(BUF_DEPTH);
   endfunction

   function automatic logic idx_in_buf(input logic [4:0] i);
      return 32'(i) < 32'(BUF_DEPTH);
   endfunction

endpackage

FILE: hw/rtl/i2cmts_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module i2cmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/i2cmts_front.sv
// Front end: accepts request items and classifies them into commands.
`timescale 1ns / 1ps

module i2cmts_front import i2cmts_pkg::*; (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_func,
   input  logic [7:0]          req_target_address,
   input  logic [POS_W-1:0]    req_transfer_length,
   input  logic [7:0]          req_bus_status,
   input  logic [7:0]          req_received_byte,
   input  logic [4:0]          req_buffer_index,
   input  logic [7:0]          req_buffer_byte,
   input  logic                push_ready,
   output hs_type              push_hs,
   output cmd_type             push_cmd
);

   logic [7:0] status_code;
   op_type     status_op;
   op_type     op;

   // The low three status bits carry prescaler noise and are ignored.
   assign status_code = {req_bus_status[7:3], 3'b000};

   always_comb begin
      unique case (status_code) inside
         ST_START, ST_RESTART:             status_op = OP_ADDR_SENT;
         ST_MT_ADDR_ACK, ST_MT_DATA_ACK:   status_op = OP_TX_ACK;
         ST_MT_ADDR_NACK, ST_MR_ADDR_NACK: status_op = OP_ADDR_NACK;
         ST_MT_DATA_NACK:                  status_op = OP_TX_DATA_NACK;
         ST_MR_ADDR_ACK:                   status_op = OP_RX_ADDR_ACK;
         ST_MR_DATA_ACK:                   status_op = OP_RX_DATA_ACK;
         ST_MR_DATA_NACK:                  status_op = OP_RX_LAST;
         default:                          status_op = OP_NONE;
      endcase
   end

   always_comb begin
      unique case (req_func) inside
         FUNC_START_WRITE, FUNC_START_READ: op = OP_START;
         FUNC_POLL:                         op = OP_POLL;
         FUNC_STATUS:                       op = status_op;
         FUNC_LOAD:                         op = OP_LOAD;
         FUNC_READ:                         op = OP_READ;
         default:                           op = OP_NONE;
      endcase
   end

   always_comb begin
      push_cmd.op      = op;
      push_cmd.rd_dir  = (req_func == FUNC_START_READ);
      push_cmd.addr    = req_target_address;
      push_cmd.len     = req_transfer_length;
      push_cmd.rx_byte = req_received_byte;
      push_cmd.bidx    = req_buffer_index;
      push_cmd.bbyte   = req_buffer_byte;
   end

   assign req_ready     = push_ready;
   assign push_hs.valid = req_valid;
   assign push_hs.ready = push_ready;

endmodule

FILE: hw/rtl/i2cmts_queue.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module i2cmts_queue import i2cmts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  hs_type  push_hs,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd,
   output logic [QUEUE_CW-1:0] fill
);

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_hs.valid && push_hs.ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign fill       = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/i2cmts_back.sv
// Back end: transfer state, receive buffer and the registered result item.
`timescale 1ns / 1ps

module i2cmts_back import i2cmts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [3:0]       csr_wr_data,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  cmd_type          pop_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_refused,
   output logic             rsp_finished,
   output logic             rsp_drive_start,
   output logic             rsp_drive_stop,
   output logic             rsp_ack_enable,
   output logic             rsp_release_bus,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic [1:0]       rsp_transfer_state,
   output logic [7:0]       rsp_read_data
);

   typedef struct packed {
      logic       refused;
      logic       finished;
      logic       dstart;
      logic       dstop;
      logic       ack;
      logic       release_bus;
      logic       txv;
      logic [7:0] tx_byte;
      logic       tx_from_ram;
      logic       rd_from_ram;
      phase_type  phase;
   } res_type;

   logic [3:0]       retry_limit_ff;
   phase_type        phase_ff, phase_in;
   logic [3:0]       retries_ff, retries_in;
   logic [7:0]       addr_byte_ff, addr_byte_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ack_ff, ack_in;
   logic             res_valid_ff, res_valid_in;
   res_type          res_ff, res_in;

   logic             exec;
   logic [POS_W-1:0] pos_next;
   logic             ram_we, ram_re;
   logic [BUF_AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]       ram_wdata, ram_q;

   assign pop_ready = !res_valid_ff || rsp_ready;
   assign exec      = pop_valid && pop_ready;
   assign pos_next  = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      retries_in   = retries_ff;
      addr_byte_in = addr_byte_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      ack_in       = ack_ff;
      res_in       = '0;
      ram_we       = 1'b0;
      ram_waddr    = BUF_AW'(pos_ff);
      ram_wdata    = pop_cmd.rx_byte;
      ram_re       = 1'b0;
      ram_raddr    = BUF_AW'(pos_ff);

      unique case (pop_cmd.op)
         OP_START: begin
            if (phase_ff == PH_BUSY) begin
               res_in.refused = 1'b1;
            end else begin
               phase_in     = PH_BUSY;
               retries_in   = '0;
               addr_byte_in = pop_cmd.rd_dir ? (pop_cmd.addr | ADDR_READ_BIT)
                                             : (pop_cmd.addr & ADDR_WRITE_MASK);
               len_in       = pop_cmd.len;
               res_in.dstart = 1'b1;
            end
         end
         OP_POLL: begin
            if (phase_ff == PH_SUCCESS || phase_ff == PH_FAILURE) begin
               phase_in        = PH_FREE;
               res_in.finished = 1'b1;
            end
         end
         OP_ADDR_SENT: begin
            res_in.txv         = 1'b1;
            res_in.tx_byte     = addr_byte_ff;
            pos_in             = '0;
            res_in.release_bus = 1'b1;
         end
         OP_TX_ACK: begin
            if (pos_ff < len_ff) begin
               res_in.txv = 1'b1;
               if (pos_in_buf(pos_ff)) begin
                  ram_re             = 1'b1;
                  res_in.tx_from_ram = 1'b1;
               end
               pos_in = pos_next;
            end else begin
               res_in.dstop = 1'b1;
               phase_in     = PH_SUCCESS;
            end
            res_in.release_bus = 1'b1;
         end
         OP_ADDR_NACK: begin
            if (retries_ff < retry_limit_ff) begin
               res_in.dstart = 1'b1;
               retries_in    = retries_ff + 1'b1;
            end else begin
               res_in.dstop = 1'b1;
               phase_in     = PH_FAILURE;
            end
            res_in.release_bus = 1'b1;
         end
         OP_TX_DATA_NACK: begin
            res_in.dstop       = 1'b1;
            phase_in           = PH_SUCCESS;
            res_in.release_bus = 1'b1;
         end
         OP_RX_ADDR_ACK: begin
            ack_in             = (len_ff > POS_W'(1));
            res_in.release_bus = 1'b1;
         end
         OP_RX_DATA_ACK: begin
            ram_we = pos_in_buf(pos_ff);
            pos_in = pos_next;
            // Drop the ACK once the next byte is the last one of the transfer.
            if (len_ff != '0 && pos_next == len_ff - 1'b1) begin
               ack_in = 1'b0;
            end
            res_in.release_bus = 1'b1;
         end
         OP_RX_LAST: begin
            phase_in           = PH_SUCCESS;
            ram_we             = pos_in_buf(pos_ff);
            pos_in             = pos_next;
            res_in.dstop       = 1'b1;
            res_in.release_bus = 1'b1;
         end
         OP_LOAD: begin
            ram_we    = idx_in_buf(pop_cmd.bidx);
            ram_waddr = BUF_AW'(pop_cmd.bidx);
            ram_wdata = pop_cmd.bbyte;
         end
         OP_READ: begin
            ram_re             = idx_in_buf(pop_cmd.bidx);
            ram_raddr          = BUF_AW'(pop_cmd.bidx);
            res_in.rd_from_ram = idx_in_buf(pop_cmd.bidx);
         end
         default: begin
         end
      endcase

      res_in.ack   = ack_in;
      res_in.phase = phase_in;
   end

   assign res_valid_in = exec ? 1'b1 : (rsp_ready ? 1'b0 : res_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
         phase_ff       <= PH_FREE;
         retries_ff     <= '0;
         addr_byte_ff   <= '0;
         len_ff         <= '0;
         pos_ff         <= '0;
         ack_ff         <= 1'b0;
         res_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            retry_limit_ff <= csr_wr_data;
         end
         if (exec) begin
            phase_ff     <= phase_in;
            retries_ff   <= retries_in;
            addr_byte_ff <= addr_byte_in;
            len_ff       <= len_in;
            pos_ff       <= pos_in;
            ack_ff       <= ack_in;
         end
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         res_ff <= res_in;
      end
   end

   i2cmts_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (exec && ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (exec && ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // The RAM read register holds while the result waits, because no new
   // command executes until the result register frees up.
   assign rsp_valid          = res_valid_ff;
   assign rsp_refused        = res_ff.refused;
   assign rsp_finished       = res_ff.finished;
   assign rsp_drive_start    = res_ff.dstart;
   assign rsp_drive_stop     = res_ff.dstop;
   assign rsp_ack_enable     = res_ff.ack;
   assign rsp_release_bus    = res_ff.release_bus;
   assign rsp_tx_valid       = res_ff.txv;
   assign rsp_tx_byte        = res_ff.tx_from_ram ? ram_q : res_ff.tx_byte;
   assign rsp_transfer_state = res_ff.phase;
   assign rsp_read_data      = res_ff.rd_from_ram ? ram_q : 8'h00;

endmodule

FILE: hw/rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer.
`timescale 1ns / 1ps

// The sequencer drives an I2C master transfer from the two-wire bus status
// codes that the bus controller reports. Each request item is one of: start
// write, start read, poll finished, bus status, load buffer or read buffer,
// and each produces exactly one response item with the bus actions to take
// (start, stop, byte to send, ACK setting), the transfer state after the
// item and, for a buffer read, the stored byte. A start is refused while a
// transfer is busy; an address NACK in either direction retries with a
// repeated start up to retry_limit times (csr_wr_data, reset value 5).
// Throughput is one item per clock while rsp_ready stays high: the front
// end classifies an item as it is accepted into a two-entry command queue,
// the back end executes the head command against the transfer state and
// the 32-byte receive buffer RAM, and the result sits in an output
// register that accepts a new item in the same cycle it is taken. An
// accepted item is written into the queue register and then executed
// into the result register, while the buffer RAM's registered read runs
// alongside the result register and adds no stage. The buffer needs no
// clearing after reset; reading an entry that was never written returns
// an undefined byte. The retry limit may be written only while no item is
// in flight.
module i2c_master_transfer_sequencer import i2cmts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_func,
   input  logic [7:0]       req_target_address,
   input  logic [5:0]       req_transfer_length,
   input  logic [7:0]       req_bus_status,
   input  logic [7:0]       req_received_byte,
   input  logic [4:0]       req_buffer_index,
   input  logic [7:0]       req_buffer_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_refused,
   output logic             rsp_finished,
   output logic             rsp_drive_start,
   output logic             rsp_drive_stop,
   output logic             rsp_ack_enable,
   output logic             rsp_release_bus,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic [1:0]       rsp_transfer_state,
   output logic [7:0]       rsp_read_data,
   input  logic             csr_wr_en,
   input  logic [3:0]       csr_wr_data
);

   hs_type                push_hs;
   cmd_type               push_cmd;
   logic                  push_ready;
   logic                  pop_valid;
   logic                  pop_ready;
   cmd_type               pop_cmd;
   logic [QUEUE_CW-1:0]   queue_fill;

   // Front end: handshake and classification of the incoming item.
   i2cmts_front u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_target_address  (req_target_address),
      .req_transfer_length (req_transfer_length),
      .req_bus_status      (req_bus_status),
      .req_received_byte   (req_received_byte),
      .req_buffer_index    (req_buffer_index),
      .req_buffer_byte     (req_buffer_byte),
      .push_ready          (push_ready),
      .push_hs             (push_hs),
      .push_cmd            (push_cmd)
   );

   // Command queue: lets the front keep accepting while the back stalls.
   i2cmts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_hs    (push_hs),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .fill       (queue_fill)
   );

   // Back end: executes commands and presents the response item.
   i2cmts_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_cmd            (pop_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_refused        (rsp_refused),
      .rsp_finished       (rsp_finished),
      .rsp_drive_start    (rsp_drive_start),
      .rsp_drive_stop     (rsp_drive_stop),
      .rsp_ack_enable     (rsp_ack_enable),
      .rsp_release_bus    (rsp_release_bus),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_transfer_state (rsp_transfer_state),
      .rsp_read_data      (rsp_read_data)
   );

`ifndef NO_ASSERTIONS
   // A refused start leaves the transfer busy.
   a_refused_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |-> rsp_transfer_state == PH_BUSY)
      else $error("refused start without a busy transfer");

   // A successful poll always frees the transfer.
   a_finished_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_transfer_state == PH_FREE)
      else $error("poll finished but transfer not free");

   // Start and stop are never requested together.
   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_drive_start && rsp_drive_stop))
      else $error("start and stop requested together");

   // The command queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_fill <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("command queue overflow");
`endif

endmodule
